### rtl/kvsv_pkg.sv
// ============================================================================
// kvsv_pkg
// Types, key patterns, verdict codes and the key match function for the
// key/value string validator.
// ============================================================================
package kvsv_pkg;

    // Bytes of history kept behind the current byte
    localparam int HistDepth = 14;
    // Longest key pattern, backslashes included
    localparam int KeyMaxLen = HistDepth + 1;

    typedef logic [7:0] char_t;
    typedef char_t      hist_t    [HistDepth];
    typedef char_t      key_pat_t [KeyMaxLen];
    typedef logic [1:0] key_cnt_t;
    typedef logic [3:0] key_len_t;

    localparam char_t CharNul = 8'h00;
    localparam char_t CharBsl = 8'h5C;

    // Key saturation point
    localparam key_cnt_t KeyCntMax = 2'd2;

    // Key patterns stored newest byte first: entry 0 is the closing backslash
    localparam key_pat_t KeyIp = '{0: CharBsl, 1: "p", 2: "i", 3: CharBsl,
                                   default: CharNul};
    localparam key_len_t KeyIpLen = 4'd4;

    localparam key_pat_t KeyGuid = '{0: CharBsl, 1: "d", 2: "i", 3: "u", 4: "g",
                                     5: "_", 6: "l", 7: "c", 8: CharBsl,
                                     default: CharNul};
    localparam key_len_t KeyGuidLen = 4'd9;

    localparam key_pat_t KeyName = '{0: CharBsl, 1: "e", 2: "m", 3: "a", 4: "n",
                                     5: CharBsl, default: CharNul};
    localparam key_len_t KeyNameLen = 4'd6;

    localparam key_pat_t KeyPb = '{0: CharBsl, 1: "r", 2: "e", 3: "t", 4: "s",
                                   5: "u", 6: "b", 7: "k", 8: "n", 9: "u",
                                   10: "p", 11: "_", 12: "l", 13: "c",
                                   14: CharBsl};
    localparam key_len_t KeyPbLen = 4'd15;

    typedef enum logic [3:0] {
        VERDICT_CLEAN     = 4'd0,
        VERDICT_EMPTY     = 4'd1,
        VERDICT_NO_LEAD   = 4'd2,
        VERDICT_TRAIL     = 4'd3,
        VERDICT_ODD       = 4'd4,
        VERDICT_DUP_IP    = 4'd5,
        VERDICT_DUP_GUID  = 4'd6,
        VERDICT_DUP_NAME  = 4'd7,
        VERDICT_DUP_PB    = 4'd8
    } verdict_t;

    // True when the key ends at the current byte
    function automatic logic key_ends(input hist_t hist, input char_t cur,
                                      input key_pat_t pat, input key_len_t len);
        logic hit;
        hit = (cur == pat[0]);
        for (int k = 1; k < KeyMaxLen; k++) begin
            if (k < int'(len)) begin
                hit = hit & (hist[k-1] == pat[k]);
            end
        end
        return hit;
    endfunction

    // Count up, saturating
    function automatic key_cnt_t key_bump(input key_cnt_t cnt);
        return (cnt >= KeyCntMax) ? KeyCntMax : key_cnt_t'(cnt + 2'd1);
    endfunction

endpackage

### rtl/key_value_string_validator.sv
// ============================================================================
// key_value_string_validator
// Scans a backslash-separated key/value string one byte per transfer and
// returns a verdict when the terminating zero byte arrives.
// ============================================================================
// The verdict is registered into the output slot, or the skid slot if stalled.
// Throughput: one byte per cycle unless the skid is full; one pass per byte.
// A stalled result parks in a one-entry skid register, so the input keeps
// flowing until both output slots are full.
// Reset (aresetn low, synchronous) clears scan state, the extra key enable
// and both output slots.
module key_value_string_validator (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write: extra_key_checks
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    // Input bytes
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] char_byte
    // Verdicts
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // [3:0] verdict, [4] is_bad, [7:5] zero
);

    kvsv_pkg::hist_t    hist_reg, hist_next;
    logic               seen_reg, seen_next;
    logic               lead_reg, lead_next;
    logic               parity_reg, parity_next;
    kvsv_pkg::key_cnt_t ip_cnt_reg, ip_cnt_next;
    kvsv_pkg::key_cnt_t guid_cnt_reg, guid_cnt_next;
    kvsv_pkg::key_cnt_t name_cnt_reg, name_cnt_next;
    kvsv_pkg::key_cnt_t pb_cnt_reg, pb_cnt_next;
    logic               extra_reg;

    logic               out_valid_reg, skid_valid_reg;
    kvsv_pkg::verdict_t out_verdict_reg, skid_verdict_reg;
    kvsv_pkg::verdict_t verdict;

    logic               in_xfer;
    logic               end_xfer;
    kvsv_pkg::char_t    cur;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~skid_valid_reg;
    assign in_xfer   = s_tvalid & s_tready;
    assign cur       = s_tdata;
    assign end_xfer  = in_xfer & (cur == kvsv_pkg::CharNul);

    // Hold the extra key enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extra_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            extra_reg <= cfg_data;
        end
    end

    // Grade the finished string, first failing check wins
    always_comb begin
        priority if (!seen_reg) begin
            verdict = kvsv_pkg::VERDICT_EMPTY;
        end else if (!lead_reg) begin
            verdict = kvsv_pkg::VERDICT_NO_LEAD;
        end else if (hist_reg[0] == kvsv_pkg::CharBsl) begin
            verdict = kvsv_pkg::VERDICT_TRAIL;
        end else if (parity_reg) begin
            verdict = kvsv_pkg::VERDICT_ODD;
        end else if (ip_cnt_reg >= kvsv_pkg::KeyCntMax) begin
            verdict = kvsv_pkg::VERDICT_DUP_IP;
        end else if (extra_reg && guid_cnt_reg >= kvsv_pkg::KeyCntMax) begin
            verdict = kvsv_pkg::VERDICT_DUP_GUID;
        end else if (name_cnt_reg >= kvsv_pkg::KeyCntMax) begin
            verdict = kvsv_pkg::VERDICT_DUP_NAME;
        end else if (extra_reg && pb_cnt_reg >= kvsv_pkg::KeyCntMax) begin
            verdict = kvsv_pkg::VERDICT_DUP_PB;
        end else begin
            verdict = kvsv_pkg::VERDICT_CLEAN;
        end
    end

    // Advance the scan state on each byte, clear it on the terminator
    always_comb begin
        hist_next     = hist_reg;
        seen_next     = seen_reg;
        lead_next     = lead_reg;
        parity_next   = parity_reg;
        ip_cnt_next   = ip_cnt_reg;
        guid_cnt_next = guid_cnt_reg;
        name_cnt_next = name_cnt_reg;
        pb_cnt_next   = pb_cnt_reg;
        if (end_xfer) begin
            for (int k = 0; k < kvsv_pkg::HistDepth; k++) begin
                hist_next[k] = kvsv_pkg::CharNul;
            end
            seen_next     = 1'b0;
            lead_next     = 1'b0;
            parity_next   = 1'b0;
            ip_cnt_next   = '0;
            guid_cnt_next = '0;
            name_cnt_next = '0;
            pb_cnt_next   = '0;
        end else if (in_xfer) begin
            if (!seen_reg) begin
                lead_next = (cur == kvsv_pkg::CharBsl);
            end
            seen_next = 1'b1;
            if (cur == kvsv_pkg::CharBsl) begin
                parity_next = ~parity_reg;
            end
            if (kvsv_pkg::key_ends(hist_reg, cur, kvsv_pkg::KeyIp, kvsv_pkg::KeyIpLen)) begin
                ip_cnt_next = kvsv_pkg::key_bump(ip_cnt_reg);
            end
            if (kvsv_pkg::key_ends(hist_reg, cur, kvsv_pkg::KeyGuid,
                                   kvsv_pkg::KeyGuidLen)) begin
                guid_cnt_next = kvsv_pkg::key_bump(guid_cnt_reg);
            end
            if (kvsv_pkg::key_ends(hist_reg, cur, kvsv_pkg::KeyName,
                                   kvsv_pkg::KeyNameLen)) begin
                name_cnt_next = kvsv_pkg::key_bump(name_cnt_reg);
            end
            if (kvsv_pkg::key_ends(hist_reg, cur, kvsv_pkg::KeyPb, kvsv_pkg::KeyPbLen)) begin
                pb_cnt_next = kvsv_pkg::key_bump(pb_cnt_reg);
            end
            // Shift the byte into history, newest at entry 0
            hist_next[0] = cur;
            for (int k = 1; k < kvsv_pkg::HistDepth; k++) begin
                hist_next[k] = hist_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < kvsv_pkg::HistDepth; k++) begin
                hist_reg[k] <= kvsv_pkg::CharNul;
            end
            seen_reg     <= 1'b0;
            lead_reg     <= 1'b0;
            parity_reg   <= 1'b0;
            ip_cnt_reg   <= '0;
            guid_cnt_reg <= '0;
            name_cnt_reg <= '0;
            pb_cnt_reg   <= '0;
        end else begin
            hist_reg     <= hist_next;
            seen_reg     <= seen_next;
            lead_reg     <= lead_next;
            parity_reg   <= parity_next;
            ip_cnt_reg   <= ip_cnt_next;
            guid_cnt_reg <= guid_cnt_next;
            name_cnt_reg <= name_cnt_next;
            pb_cnt_reg   <= pb_cnt_next;
        end
    end

    // Output register with a one-entry skid behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= end_xfer;
            end
        end else if (end_xfer) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_verdict_reg <= skid_valid_reg ? skid_verdict_reg : verdict;
        end else if (end_xfer) begin
            skid_verdict_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, (out_verdict_reg != kvsv_pkg::VERDICT_CLEAN),
                       out_verdict_reg};

endmodule

### rtl/key_value_string_validator_checker.sv
// ============================================================================
// key_value_string_validator_checker
// Port-level checks on the verdict channel of the string validator.
// ============================================================================
module key_value_string_validator_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // Stalled verdict stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("verdict dropped while stalled");

    // Stalled verdict keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("verdict changed while stalled");

    // is_bad follows the verdict code
    a_bad_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4] == (m_tdata[3:0] != 4'd0)))
        else $error("is_bad disagrees with verdict");

    // Verdict code in range, pad bits zero
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= 4'd8) && (m_tdata[7:5] == 3'd0))
        else $error("verdict code out of range");

    // A verdict appears only after a terminator transfer or a waiting one
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tdata == 8'd0)
                            || $past(!s_tready))
        else $error("verdict without terminator");

endmodule

bind key_value_string_validator key_value_string_validator_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
